// File: hw/rtl/fce_pkg.sv
package fce_pkg;
  localparam int MAX_LEN    = 32;
  localparam int MAX_POINTS = 64;
  localparam int AW         = 5;
  localparam int KW         = 6;
  localparam int CW         = 21;

  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_a;
    logic [7:0]    wr_b;
    logic [AW-1:0] rd_a_addr;
    logic [AW-1:0] rd_b_addr;
  } mem_ctl_t;
endpackage

// File: hw/rtl/fce_coef_mem.sv
module fce_coef_mem (
  input  logic              clk,
  input  fce_pkg::mem_ctl_t ctl,
  output logic [7:0]        rd_a,
  output logic [7:0]        rd_b
);
  import fce_pkg::*;

  logic [7:0] a_mem [MAX_LEN];
  logic [7:0] b_mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      a_mem[ctl.wr_addr] <= ctl.wr_a;
      b_mem[ctl.wr_addr] <= ctl.wr_b;
    end
    rd_a <= a_mem[ctl.rd_a_addr];
    rd_b <= b_mem[ctl.rd_b_addr];
  end
endmodule

// File: hw/rtl/fft_convolution_engine.sv
// Convolution of two signed 8-bit sequences, one coefficient pair per word on start.
// A word with in_last closes the run: busy rises and n = 2 * next power of two >= length
// results follow on out_valid, indices 0..n-1, out_last_out on the last. Words after the
// 32nd are dropped. Results are produced one at a time, each by stepping through the
// overlapping coefficient pairs via the single coefficient memory read port pair and one
// multiply-accumulate. The receiver cannot stall: results must be taken as they appear.
module fft_convolution_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [7:0]   in_a_value,
  input  logic signed [7:0]   in_b_value,
  input  logic                in_last,
  output logic                out_valid,
  output logic signed [20:0]  out_conv_value,
  output logic [5:0]          out_index,
  output logic                out_last_out
);
  import fce_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_MAC, S_EMIT} state_t;

  state_t         state_r;
  logic [KW-1:0]  cnt_r;
  logic [KW-1:0]  k_r, n_r;
  logic [KW-1:0]  i_r;
  logic           rd_vld_r;
  logic           rd_done_r;
  logic signed [CW-1:0] acc_r;
  mem_ctl_t       ctl;
  logic [7:0]     rd_a, rd_b;
  logic [KW-1:0]  j;
  logic [KW-1:0]  cnt_eff, pw;
  logic           take, inner_end, pair_ok;
  logic signed [15:0] prod;

  assign take = start && !busy;
  assign busy = (state_r != S_LOAD);
  assign j = k_r - i_r;
  assign pair_ok = (j < cnt_r) && (i_r < cnt_r);
  assign inner_end = (i_r == k_r) || (i_r + 6'd1 == cnt_r) || (i_r >= cnt_r) ||
                     (cnt_r == '0);
  assign prod = $signed(rd_a) * $signed(rd_b);

  always_comb begin
    cnt_eff = (take && cnt_r < KW'(MAX_LEN)) ? cnt_r + 6'd1 : cnt_r;
    if (cnt_eff <= 6'd1)       pw = 6'd2;
    else if (cnt_eff <= 6'd2)  pw = 6'd4;
    else if (cnt_eff <= 6'd4)  pw = 6'd8;
    else if (cnt_eff <= 6'd8)  pw = 6'd16;
    else if (cnt_eff <= 6'd16) pw = 6'd32;
    else                       pw = 6'd0;
  end

  always_comb begin
    ctl.wr_en     = take && (cnt_r < KW'(MAX_LEN));
    ctl.wr_addr   = cnt_r[AW-1:0];
    ctl.wr_a      = in_a_value;
    ctl.wr_b      = in_b_value;
    ctl.rd_a_addr = i_r[AW-1:0];
    ctl.rd_b_addr = j[AW-1:0];
  end

  fce_coef_mem u_mem (.clk(clk), .ctl(ctl), .rd_a(rd_a), .rd_b(rd_b));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_done_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (take) begin
            cnt_r <= cnt_eff;
            if (in_last) begin
              n_r     <= pw - 6'd1;
              k_r     <= '0;
              i_r     <= '0;
              acc_r   <= '0;
              rd_vld_r <= 1'b0;
              rd_done_r <= 1'b0;
              state_r <= S_MAC;
            end
          end
        end
        S_MAC: begin
          if (!rd_done_r) begin
            rd_vld_r <= (cnt_r != '0) && pair_ok;
            if (inner_end) rd_done_r <= 1'b1;
            else i_r <= i_r + 6'd1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r) acc_r <= acc_r + CW'(prod);
          if (rd_done_r && !rd_vld_r) state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_valid      <= 1'b1;
          out_conv_value <= acc_r;
          out_index      <= k_r;
          out_last_out   <= (k_r == n_r);
          if (k_r == n_r) begin
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end else begin
            k_r       <= k_r + 6'd1;
            i_r       <= (k_r + 6'd1 >= cnt_r && cnt_r != '0) ?
                         KW'(k_r + 7'd2 - {1'b0, cnt_r}) : '0;
            acc_r     <= '0;
            rd_done_r <= 1'b0;
            state_r   <= S_MAC;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_load_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= KW'(MAX_LEN)) else $error("load count overflow");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctl.wr_en) else $error("write while busy");
  a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back results");
endmodule

// File: sim/fft_convolution_engine_checker.sv
`timescale 1ns / 1ps
module fft_convolution_engine_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [7:0]  in_a_value,
  input  logic signed [7:0]  in_b_value,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic signed [20:0] out_conv_value,
  input  logic [5:0]         out_index,
  input  logic               out_last_out,
  output int                 fail_count,
  output int                 pending
);
  import fce_pkg::*;

  typedef struct packed {
    logic signed [CW-1:0] conv_value;
    logic [KW-1:0]        index;
    logic                 last_out;
  } coef_t;

  logic signed [7:0] a_seq [MAX_LEN];
  logic signed [7:0] b_seq [MAX_LEN];
  int                pair_count;
  coef_t             coef_q [$];

  assign pending = coef_q.size();

  task automatic take_word(input logic signed [7:0] a, input logic signed [7:0] b,
                           input logic lst);
    int half;
    int len;
    int n;
    int acc;
    coef_t c;
    if (pair_count < MAX_LEN && pair_count < MAX_POINTS / 2) begin
      a_seq[pair_count] = a;
      b_seq[pair_count] = b;
      pair_count++;
    end
    if (lst) begin
      len = (pair_count == 0) ? 1 : pair_count;
      half = 1;
      while (half < len) half = half * 2;
      n = half * 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (int k = 0; k < n; k++) begin
        acc = 0;
        for (int i = 0; i < pair_count && i <= k; i++) begin
          if (k - i < pair_count) acc += int'(a_seq[i]) * int'(b_seq[k - i]);
        end
        c.conv_value = acc[CW-1:0];
        c.index = k[KW-1:0];
        c.last_out = (k == n - 1);
        coef_q = {coef_q, c};
      end
      pair_count = 0;
    end
  endtask

  always @(posedge clk) begin
    coef_t exp_c;
    if (!rst_n) begin
      pair_count = 0;
      coef_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (coef_q.size() == 0) begin
          $display("%0t: unexpected word conv=%0d index=%0d last=%0b", $time,
                   out_conv_value, out_index, out_last_out);
          fail_count++;
        end else begin
          exp_c = coef_q.pop_front();
          if (out_conv_value !== exp_c.conv_value) begin
            $display("%0t: conv_value expected %0d actual %0d", $time,
                     exp_c.conv_value, out_conv_value);
            fail_count++;
          end
          if (out_index !== exp_c.index) begin
            $display("%0t: index expected %0d actual %0d", $time, exp_c.index, out_index);
            fail_count++;
          end
          if (out_last_out !== exp_c.last_out) begin
            $display("%0t: last_out expected %0b actual %0b", $time,
                     exp_c.last_out, out_last_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) take_word(in_a_value, in_b_value, in_last);
    end
  end
endmodule

// File: sim/fft_convolution_engine_tb.sv
`timescale 1ns / 1ps
module fft_convolution_engine_tb;
  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [7:0]  in_a_value;
  logic signed [7:0]  in_b_value;
  logic               in_last;
  logic               out_valid;
  logic signed [20:0] out_conv_value;
  logic [5:0]         out_index;
  logic               out_last_out;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;

  fft_convolution_engine u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_value(in_a_value), .in_b_value(in_b_value), .in_last(in_last),
    .out_valid(out_valid), .out_conv_value(out_conv_value),
    .out_index(out_index), .out_last_out(out_last_out)
  );

  fft_convolution_engine_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_value(in_a_value), .in_b_value(in_b_value), .in_last(in_last),
    .out_valid(out_valid), .out_conv_value(out_conv_value),
    .out_index(out_index), .out_last_out(out_last_out),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_a_value = '0;
    in_b_value = '0;
    in_last = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one word: hold start until accepted; drop it before an idle gap and after the last word
  task automatic send_word(input logic [7:0] a, input logic [7:0] b, input logic lst,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_a_value <= a;
    in_b_value <= b;
    in_last <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (lst) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_run(input int len, input int mode);
    logic [7:0] a;
    logic [7:0] b;
    bit         burst;
    burst = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: begin a = 8'($urandom); b = 8'($urandom); end
        1: begin a = 8'h80; b = 8'h80; end
        2: begin a = 8'h7f; b = 8'h80; end
        default: begin a = 8'h7f; b = 8'h7f; end
      endcase
      send_word(a, b, i == len - 1, burst);
    end
  endtask

  initial begin
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_run(1, 1);
    send_run(1, 3);
    send_run(2, 2);
    send_run(3, 0);
    send_run(32, 1);
    send_run(5, 0);
    send_run(36, 0);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    for (int r = 0; r < 35; r++) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 36) : $urandom_range(1, 8);
      send_run(len, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      if (r == 17) begin
        wait (pending == 0);
        repeat (20) @(posedge clk);
      end
    end
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/fce_pkg.sv
hw/rtl/fce_coef_mem.sv
hw/rtl/fft_convolution_engine.sv
sim/fft_convolution_engine_checker.sv
sim/fft_convolution_engine_tb.sv
